[hw/rtl/tsopt_pkg.sv]
package tsopt_pkg;

  // Walk phase of the option parser
  typedef enum logic [1:0] {
    PH_KIND = 2'd0,
    PH_LEN  = 2'd1,
    PH_SKIP = 2'd2,
    PH_TS   = 2'd3
  } tsopt_phase_t;

  // Option kinds and lengths
  localparam logic [7:0] KIND_END = 8'd0;
  localparam logic [7:0] KIND_NOP = 8'd1;
  localparam logic [7:0] KIND_TS  = 8'd8;
  localparam logic [7:0] TS_LEN   = 8'd10;
  localparam logic [7:0] MIN_LEN  = 8'd2;

  // One result item
  typedef struct packed {
    logic        found;
    logic [31:0] ts_value;
    logic [31:0] ts_echo;
  } tsopt_result_t;

endpackage

[hw/rtl/tcp_timestamp_option_parser_core.sv]
// Channel | Handshake            | Payload
// --------+----------------------+--------------------------------
// input   | in_valid / in_ready  | opt_byte, last_byte, empty_area
// output  | out_valid / out_ready| found, ts_value, ts_echo
//
// One item per cycle while no header-ending item waits on a stalled output;
// an item is registered on entry and walked from the input register, its
// result (if any) leaving from the output register. Synchronous reset rst
// clears the walk and both valid flags. A stalled output only holds back
// items that end a header; other bytes keep flowing while a result waits.
module tcp_timestamp_option_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  opt_byte,
  input  logic        last_byte,
  input  logic        empty_area,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [31:0] ts_value,
  output logic [31:0] ts_echo
);
  import tsopt_pkg::*;

  logic          in_q_valid;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          empty_q;
  logic          step;
  logic          emit;
  logic          can_load;
  tsopt_result_t walk_result;
  tsopt_result_t out_data;

  // Only header-ending items need room in the result register
  assign step     = in_q_valid && (!emit || can_load);
  assign in_ready = !in_q_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q  <= opt_byte;
      last_q  <= last_byte;
      empty_q <= empty_area;
    end
  end

  tsopt_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .opt_byte   (byte_q),
    .last_byte  (last_q),
    .empty_area (empty_q),
    .emit       (emit),
    .result     (walk_result)
  );

  tsopt_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit),
    .load_data (walk_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign found    = out_data.found;
  assign ts_value = out_data.ts_value;
  assign ts_echo  = out_data.ts_echo;

  // Not-found results carry zero values
  a_zero_when_absent: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> ts_value == 32'd0 && ts_echo == 32'd0)
    else $error("result values nonzero without a timestamp");

  // A header-ending item always produces a result next cycle
  a_emit_lands: assert property (@(posedge clk) disable iff (rst)
    step && emit |=> out_valid)
    else $error("header end produced no result");

  // A held input item keeps its payload
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_q_valid && !step |=> in_q_valid && $stable(byte_q) && $stable(last_q)
      && $stable(empty_q))
    else $error("stalled input item changed");

endmodule

[hw/rtl/tsopt_walk.sv]
module tsopt_walk (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  logic [7:0]              opt_byte,
  input  logic                    last_byte,
  input  logic                    empty_area,
  output logic                    emit,
  output tsopt_pkg::tsopt_result_t result
);
  import tsopt_pkg::*;

  tsopt_phase_t phase, phase_next;
  logic [7:0]   option_kind, option_kind_next;
  logic [7:0]   bytes_left, bytes_left_next;
  logic [63:0]  capture, capture_next;
  logic         found_flag, found_flag_next;
  logic         walk_done, walk_done_next;
  logic [7:0]   left_dec;
  logic [7:0]   len_body;

  assign left_dec = bytes_left - 8'd1;
  assign len_body = opt_byte - MIN_LEN;
  assign emit     = last_byte || empty_area;

  // Per-byte walk of kind/length/body
  always_comb begin
    phase_next       = phase;
    option_kind_next = option_kind;
    bytes_left_next  = bytes_left;
    capture_next     = capture;
    found_flag_next  = found_flag;
    walk_done_next   = walk_done;
    if (!walk_done) begin
      case (phase)
        PH_KIND: begin
          option_kind_next = opt_byte;
          if (opt_byte == KIND_END) begin
            walk_done_next = 1'b1;
          end else if (opt_byte != KIND_NOP) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (opt_byte < MIN_LEN) begin
            walk_done_next = 1'b1;
          end else begin
            bytes_left_next = len_body;
            capture_next    = '0;
            if (len_body == 8'd0) begin
              phase_next = PH_KIND;
            end else if (option_kind == KIND_TS && opt_byte == TS_LEN) begin
              phase_next = PH_TS;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_TS: begin
          capture_next    = {capture[55:0], opt_byte};
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            found_flag_next = 1'b1;
            walk_done_next  = 1'b1;
            phase_next      = PH_KIND;
          end
        end
        default: begin
          // skipping a body; a zero count drops straight back to kind
          if (bytes_left != 8'd0) begin
            bytes_left_next = left_dec;
          end
          if (bytes_left <= 8'd1) begin
            phase_next = PH_KIND;
          end
        end
      endcase
    end
  end

  // Result of this item, valid when emit is set
  always_comb begin
    result = '0;
    if (!empty_area && found_flag_next) begin
      result.found    = 1'b1;
      result.ts_value = capture_next[63:32];
      result.ts_echo  = capture_next[31:0];
    end
  end

  // Walk state; cleared at the end of each header
  always_ff @(posedge clk) begin
    if (rst || (step && emit)) begin
      phase       <= PH_KIND;
      option_kind <= '0;
      bytes_left  <= '0;
      capture     <= '0;
      found_flag  <= 1'b0;
      walk_done   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      option_kind <= option_kind_next;
      bytes_left  <= bytes_left_next;
      capture     <= capture_next;
      found_flag  <= found_flag_next;
      walk_done   <= walk_done_next;
    end
  end

endmodule

[hw/rtl/tsopt_out_reg.sv]
module tsopt_out_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  tsopt_pkg::tsopt_result_t load_data,
  output logic                    can_load,
  output logic                    out_valid,
  input  logic                    out_ready,
  output tsopt_pkg::tsopt_result_t out_data
);
  import tsopt_pkg::*;

  tsopt_result_t data_q;

  assign can_load = !out_valid || out_ready;
  assign out_data = data_q;

  // Result register: refilled in the cycle its item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_q <= load_data;
    end
  end

endmodule
